// File: sv/mtcr_pkg.sv
package mtcr_pkg;

	localparam int FONT_DEPTH_DEF = 8192;
	localparam int FONT_ADDR_W    = 13;
	localparam int CELL_WIDTH     = 9;
	localparam int PIX_POS_W      = 4;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0]  ATTR_FGBG_MASK    = 8'b0111_0111;
	localparam logic [7:0]  ATTR_REVERSE      = 8'b0111_0000;
	localparam logic [7:0]  BOX_FIRST         = 8'hC0;
	localparam logic [7:0]  BOX_LAST          = 8'hDF;
	localparam logic [12:0] LOWER_HALF_OFFSET = 13'(1 << 11);
	localparam logic [3:0]  COLOR_FULL        = 4'hF;
	localparam logic [2:0]  FG_ON             = 3'b111;

	localparam logic [2:0] REG_BLINK_EN  = 3'd0;
	localparam logic [2:0] REG_VIDEO_EN  = 3'd1;
	localparam logic [2:0] REG_MAX_SL    = 3'd2;
	localparam logic [2:0] REG_CUR_START = 3'd3;
	localparam logic [2:0] REG_CUR_END   = 3'd4;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	typedef struct packed {
		logic       blink_en;
		logic       video_en;
		logic [4:0] max_sl;
		logic [4:0] cur_start;
		logic [4:0] cur_end;
	} cfg_t;

	typedef struct packed {
		logic                   is_draw;
		logic [FONT_ADDR_W-1:0] addr;
		logic [7:0]             wbyte;
		logic [3:0]             fg;
		logic [3:0]             bg;
		logic                   draw;
		logic                   underline;
		logic                   cline;
		logic                   box;
	} entry_t;

endpackage

// File: sv/mono_text_cell_renderer.sv
// Draws pass the queue, font read stage, serializer and output register; the read
// stage takes the next cell while the serializer is busy, which gives one pixel per
// cycle while cells arrive and m_tready does not stall. A load transfer writes the
// font memory port, also while pixels stream. Two-entry queue between decode and the
// font read / pixel serializer. Reset (arst_n low, async): queue, pipeline and output
// valid cleared, registers to blink 0, video 0, max scanline 13, cursor 11..12; font memory is not cleared.
module mono_text_cell_renderer #(
	parameter int FONT_DEPTH = mtcr_pkg::FONT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// font_addr, font_byte, char_code, attribute, scan_row, at_cursor,
	// blink_phase, in_display, zero pad
	input  logic [47:0] s_tdata,
	// req_type
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_color, pixel_pos, dot_on, zero pad
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mtcr_pkg::*;

	cfg_t   cfg_q;
	entry_t front_ent;
	entry_t q_head;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	logic   reg_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_en  <= 1'b0;
			cfg_q.video_en  <= 1'b0;
			cfg_q.max_sl    <= 5'd13;
			cfg_q.cur_start <= 5'd11;
			cfg_q.cur_end   <= 5'd12;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_BLINK_EN:  cfg_q.blink_en  <= pwdata[0];
				REG_VIDEO_EN:  cfg_q.video_en  <= pwdata[0];
				REG_MAX_SL:    cfg_q.max_sl    <= pwdata[4:0];
				REG_CUR_START: cfg_q.cur_start <= pwdata[4:0];
				REG_CUR_END:   cfg_q.cur_end   <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BLINK_EN:  prdata = {31'd0, cfg_q.blink_en};
			REG_VIDEO_EN:  prdata = {31'd0, cfg_q.video_en};
			REG_MAX_SL:    prdata = {27'd0, cfg_q.max_sl};
			REG_CUR_START: prdata = {27'd0, cfg_q.cur_start};
			REG_CUR_END:   prdata = {27'd0, cfg_q.cur_end};
			default:       prdata = 32'd0;
		endcase
	end

	assign s_tready = !q_full;

	mtcr_front #(
		.FONT_DEPTH(FONT_DEPTH)
	) u_front (
		.req_type   (s_tuser[0]),
		.font_addr  (s_tdata[12:0]),
		.font_byte  (s_tdata[20:13]),
		.char_code  (s_tdata[28:21]),
		.attribute  (s_tdata[36:29]),
		.scan_row   (s_tdata[41:37]),
		.at_cursor  (s_tdata[42]),
		.blink_phase(s_tdata[43]),
		.in_display (s_tdata[44]),
		.cfg        (cfg_q),
		.ent        (front_ent)
	);

	mtcr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (s_tvalid),
		.push_ent(front_ent),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_head)
	);

	mtcr_back #(
		.FONT_DEPTH(FONT_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// File: sv/mtcr_front.sv
module mtcr_front #(
	parameter int FONT_DEPTH = mtcr_pkg::FONT_DEPTH_DEF
) (
	input  logic            req_type,
	input  logic [12:0]     font_addr,
	input  logic [7:0]      font_byte,
	input  logic [7:0]      char_code,
	input  logic [7:0]      attribute,
	input  logic [4:0]      scan_row,
	input  logic            at_cursor,
	input  logic            blink_phase,
	input  logic            in_display,
	input  mtcr_pkg::cfg_t  cfg,
	output mtcr_pkg::entry_t ent
);
	import mtcr_pkg::*;

	logic       blank;
	logic       reverse;
	logic       char_blink;
	logic       ul_attr;
	logic       draw;
	logic [3:0] fg;
	logic [FONT_ADDR_W-1:0] load_addr;
	logic [FONT_ADDR_W-1:0] draw_addr;

	always_comb begin
		blank      = !in_display || !cfg.video_en;
		reverse    = (attribute & ATTR_FGBG_MASK) == ATTR_REVERSE;
		char_blink = cfg.blink_en && attribute[7];
		ul_attr    = attribute[2:0] == 3'd1;
		draw       = !char_blink || blink_phase;
		if ((attribute & ATTR_FGBG_MASK) != 8'd0) begin
			fg = {attribute[3], FG_ON};
		end else begin
			fg = 4'd0;
		end
		if (reverse) begin
			fg = fg ^ {1'b0, FG_ON};
		end

		if ({1'b0, font_addr} >= 14'(FONT_DEPTH)) begin
			load_addr = FONT_ADDR_W'({1'b0, font_addr} - 14'(FONT_DEPTH));
		end else begin
			load_addr = font_addr;
		end
		draw_addr = FONT_ADDR_W'({char_code, scan_row[2:0]})
			+ ((scan_row[4:3] != 2'd0) ? LOWER_HALF_OFFSET : 13'd0);

		ent.is_draw = req_type == REQ_DRAW;
		ent.addr    = ent.is_draw ? draw_addr : load_addr;
		ent.wbyte   = font_byte;
		if (blank) begin
			ent.fg        = 4'd0;
			ent.bg        = 4'd0;
			ent.draw      = 1'b0;
			ent.underline = 1'b0;
			ent.cline     = 1'b0;
			ent.box       = 1'b0;
		end else begin
			ent.fg        = fg;
			ent.bg        = (reverse || (!cfg.blink_en && attribute[7])) ? COLOR_FULL : 4'd0;
			ent.draw      = draw;
			ent.underline = draw && ul_attr && (scan_row == cfg.max_sl);
			ent.cline     = at_cursor && (scan_row >= cfg.cur_start)
				&& (scan_row <= cfg.cur_end);
			ent.box       = (char_code >= BOX_FIRST) && (char_code <= BOX_LAST);
		end
	end

endmodule

// File: sv/mtcr_queue.sv
module mtcr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mtcr_pkg::entry_t push_ent,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output mtcr_pkg::entry_t head
);
	import mtcr_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == CW'(QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// File: sv/mtcr_back.sv
module mtcr_back #(
	parameter int FONT_DEPTH = mtcr_pkg::FONT_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mtcr_pkg::entry_t q_head,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,
	output logic             m_tlast
);
	import mtcr_pkg::*;

	localparam int AW = $clog2(FONT_DEPTH);

	logic [7:0] font_mem [FONT_DEPTH];

	logic                 valid_s1;
	entry_t               ent_s1;
	logic [7:0]           glyph_s1;
	logic                 sr_active_q;
	entry_t               sr_ent_q;
	logic [7:0]           sr_glyph_q;
	logic [PIX_POS_W-1:0] sr_cnt_q;
	logic                 out_valid_q;
	logic [3:0]           out_color_q;
	logic [PIX_POS_W-1:0] out_pos_q;
	logic                 out_dot_q;
	logic                 out_last_q;

	logic sr_last;
	logic emit;
	logic s1_move;
	logic s1_free;
	logic pix_dot;
	logic [3:0] pix_color;

	always_comb begin
		sr_last = sr_cnt_q == PIX_POS_W'(CELL_WIDTH - 1);
		emit    = sr_active_q && (!out_valid_q || m_tready);
		s1_move = valid_s1 && (!sr_active_q || (emit && sr_last));
		s1_free = !valid_s1 || s1_move;
		q_pop   = q_valid && (!q_head.is_draw || s1_free);
		if (sr_cnt_q == PIX_POS_W'(CELL_WIDTH - 1)) begin
			pix_dot = sr_ent_q.draw && sr_ent_q.box && sr_glyph_q[0];
		end else begin
			pix_dot = sr_ent_q.draw && sr_glyph_q[~sr_cnt_q[2:0]];
		end
		pix_color = (pix_dot || sr_ent_q.cline || sr_ent_q.underline)
			? sr_ent_q.fg : sr_ent_q.bg;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_head.is_draw) begin
				glyph_s1 <= font_mem[q_head.addr[AW-1:0]];
			end else begin
				font_mem[q_head.addr[AW-1:0]] <= q_head.wbyte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.is_draw) begin
			ent_s1 <= q_head;
		end
		if (s1_move) begin
			sr_ent_q   <= ent_s1;
			sr_glyph_q <= glyph_s1;
		end
		if (emit) begin
			out_color_q <= pix_color;
			out_pos_q   <= sr_cnt_q;
			out_dot_q   <= pix_dot;
			out_last_q  <= sr_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			sr_active_q <= 1'b0;
			sr_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_head.is_draw) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				sr_active_q <= 1'b1;
				sr_cnt_q    <= '0;
			end else if (emit) begin
				sr_cnt_q <= sr_cnt_q + 1'b1;
				if (sr_last) begin
					sr_active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_dot_q, out_pos_q, out_color_q};
	assign m_tlast  = out_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		sr_active_q |-> sr_cnt_q <= PIX_POS_W'(CELL_WIDTH - 1))
		else $error("pixel counter past cell width");

	a_no_s1_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.is_draw) |-> s1_free)
		else $error("draw popped into busy read stage");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[7:4] == PIX_POS_W'(CELL_WIDTH - 1))))
		else $error("tlast not on ninth pixel");

	a_cell_start: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> (sr_active_q && sr_cnt_q == '0))
		else $error("cell did not start at pixel zero");

endmodule
